// File: hdl/sbcd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// sbcd_pkg - shared types and constants of the segment bus capture decoder
// Result status codes, controller/datapath command and status groups, and the
// seven-segment code table used by the digit decoder.
// ============================================================================
package sbcd_pkg;

    localparam int READING_W = 16;
    localparam int BUDGET_W  = 16;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TIMEOUT  = 2'd1,
        ST_BADCODE  = 2'd2,
        ST_RESERVED = 2'd3
    } status_t;

    // A decoded value that the display uses as a marker and is never reported.
    localparam logic [READING_W-1:0] RESERVED_VALUE = 16'd2080;

    // Bits of the high byte that carry segments.
    localparam logic [7:0] SEG_MASK = 8'h77;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;          // new capture: load budget, clear edge and bit count
        logic clear_cap;     // frame went low: clear edge and bit count
        logic spend;         // waiting transaction uses one unit of budget
        logic arm;           // clock seen low
        logic disarm;        // capture abandoned on timeout
        logic sample;        // clock rising edge: take one data bit
        logic dec_start;     // last bit taken: reset the digit accumulator
        logic dec_step;      // fold one digit pair into the accumulator
        logic emit_timeout;  // write a timeout result to the output register
        logic emit_decode;   // write the decoded result to the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic edge_armed;
        logic budget_low;    // budget at zero or one
        logic last_bit;      // the bit about to be taken ends the frame
        logic dec_last;      // the current pair is the least significant one
        logic dec_bad;       // the current pair is not a known segment code
        logic out_space;     // the output register can take a result this cycle
    } stat_t;

    // Builds the segment code from a pair of kept bytes.
    function automatic logic [7:0] seg_code(input logic [7:0] hi, input logic [7:0] lo);
        seg_code = 8'((hi & SEG_MASK) << 1) | 8'(lo >> 7);
    endfunction

    // Maps a segment code to {found, digit}; a blank code counts as zero.
    function automatic logic [4:0] seg_lookup(input logic [7:0] code);
        logic [4:0] r;
        unique case (code)
            8'haf:   r = {1'b1, 4'd0};
            8'h06:   r = {1'b1, 4'd1};
            8'h6d:   r = {1'b1, 4'd2};
            8'h4f:   r = {1'b1, 4'd3};
            8'hc6:   r = {1'b1, 4'd4};
            8'hcb:   r = {1'b1, 4'd5};
            8'heb:   r = {1'b1, 4'd6};
            8'h0e:   r = {1'b1, 4'd7};
            8'hef:   r = {1'b1, 4'd8};
            8'hcf:   r = {1'b1, 4'd9};
            8'h00:   r = {1'b1, 4'd0};
            default: r = {1'b0, 4'd0};
        endcase
        seg_lookup = r;
    endfunction

endpackage

// File: hdl/sbcd_if.sv
`timescale 1ns / 1ps
// ============================================================================
// sbcd_if - stream interfaces of the segment bus capture decoder
// Input samples channel and result channel, each with valid/ready handshake.
// ============================================================================
interface sbcd_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic frame_level;
    logic clock_level;
    logic data_level;

    modport source (output valid, start_req, frame_level, clock_level, data_level,
                    input ready);
    modport sink (input valid, start_req, frame_level, clock_level, data_level,
                  output ready);
endinterface

interface sbcd_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] reading;
    logic [1:0]  status;

    modport source (output valid, reading, status, input ready);
    modport sink (input valid, reading, status, output ready);
endinterface

// File: hdl/segment_bus_capture_decoder_core.sv
`timescale 1ns / 1ps
// ============================================================================
// segment_bus_capture_decoder_core - display bus capture and digit decoder
// Sniffs a display serial bus one sample per transaction, keeps the digit
// bytes of a frame and reports the decoded reading with a status.
// ============================================================================
//
//  Channel   Direction  Payload                                      Handshake
//  --------  ---------  -------------------------------------------  ---------
//  in_bus    sink       start_req, frame_level, clock_level,         valid/ready
//                       data_level
//  out_bus   source     reading[15:0], status[1:0]                   valid/ready
//  cfg       write      cfg_wdata[15:0] -> wait_budget               cfg_we
//
//  While idle, waiting for the frame and capturing, one input transaction is
//  taken per cycle. After the transaction that takes the last bit of the frame,
//  the input is held off while the decoder folds one byte pair a cycle through
//  the shared segment lookup and multiply-by-ten accumulator, pausing while the
//  output register is full and not being drained. It folds every pair when each
//  is a known code and stops at the first unknown pair; the result enters the
//  output register on the last fold.
//  Reset is asynchronous and active low; the block comes out idle with
//  wait_budget at 65535. The kept bytes need no clearing.
//  A result waiting in the output register is held until taken; outside the
//  decode cycles the input side stalls only while that register is full and
//  not being drained.
//
module segment_bus_capture_decoder_core #(
    parameter int FRAME_BYTES  = 58,
    parameter int DIGIT_OFFSET = 40,
    parameter int DIGIT_COUNT  = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sbcd_pkg::BUDGET_W-1:0] cfg_wdata,
    sbcd_in_if.sink                       in_bus,
    sbcd_out_if.source                    out_bus
);

    // Command and status groups between the controller and the datapath.
    sbcd_pkg::cmd_t    cmd;
    sbcd_pkg::stat_t   stat;
    sbcd_pkg::status_t out_status;

    // The controller owns the capture phase and decides, per transaction,
    // which register updates the datapath makes.
    sbcd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_bus.valid),
        .start_req   (in_bus.start_req),
        .frame_level (in_bus.frame_level),
        .clock_level (in_bus.clock_level),
        .stat        (stat),
        .in_ready    (in_bus.ready),
        .cmd         (cmd)
    );

    // The datapath holds the budget and bit counters, the kept bytes, the
    // digit accumulator and the output register.
    sbcd_datapath #(
        .FRAME_BYTES  (FRAME_BYTES),
        .DIGIT_OFFSET (DIGIT_OFFSET),
        .DIGIT_COUNT  (DIGIT_COUNT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .data_level  (in_bus.data_level),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_bus.valid),
        .out_ready   (out_bus.ready),
        .out_reading (out_bus.reading),
        .out_status  (out_status)
    );

    assign out_bus.status = out_status;

`ifndef SYNTHESIS
    // A result that is not taken must hold off new input samples.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_bus.valid && !out_bus.ready) |-> !in_bus.ready)
        else $error("input accepted while the output register is stalled");

    // A result is never written over one that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_timeout || cmd.emit_decode) |-> (!out_bus.valid || out_bus.ready))
        else $error("result written into a full output register");

    // Decoding steps only while the input side is held off.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dec_step |-> !in_bus.ready)
        else $error("input ready during digit decode");

    // The last bit of a frame leads into decoding on the next cycle unless the output register is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dec_start |=> (cmd.dec_step || (out_bus.valid && !out_bus.ready)))
        else $error("decode did not follow the last captured bit");
`endif

endmodule

// File: hdl/sbcd_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// sbcd_ctrl - capture controller
// Tracks the capture phase and issues datapath commands per transaction.
// ============================================================================
module sbcd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                start_req,
    input  logic                frame_level,
    input  logic                clock_level,
    input  sbcd_pkg::stat_t     stat,
    output logic                in_ready,
    output sbcd_pkg::cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WAIT_HIGH,
        S_WAIT_LOW,
        S_CAPTURE,
        S_DECODE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg != S_DECODE) && stat.out_space;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && start_req)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_WAIT_HIGH;
                end
            end
            S_WAIT_HIGH:
            begin
                if (accept)
                begin
                    if (frame_level)
                    begin
                        state_next = S_WAIT_LOW;
                    end
                    else
                    begin
                        cmd.spend = 1'b1;
                        if (stat.budget_low)
                        begin
                            cmd.emit_timeout = 1'b1;
                            cmd.disarm       = 1'b1;
                            state_next       = S_IDLE;
                        end
                    end
                end
            end
            S_WAIT_LOW:
            begin
                if (accept)
                begin
                    if (!frame_level)
                    begin
                        cmd.clear_cap = 1'b1;
                        state_next    = S_CAPTURE;
                    end
                    else
                    begin
                        cmd.spend = 1'b1;
                        if (stat.budget_low)
                        begin
                            cmd.emit_timeout = 1'b1;
                            cmd.disarm       = 1'b1;
                            state_next       = S_IDLE;
                        end
                    end
                end
            end
            S_CAPTURE:
            begin
                if (accept)
                begin
                    if (stat.edge_armed && clock_level)
                    begin
                        cmd.sample = 1'b1;
                        if (stat.last_bit)
                        begin
                            cmd.dec_start = 1'b1;
                            state_next    = S_DECODE;
                        end
                    end
                    else
                    begin
                        cmd.arm   = !clock_level;
                        cmd.spend = 1'b1;
                        if (stat.budget_low)
                        begin
                            cmd.emit_timeout = 1'b1;
                            cmd.disarm       = 1'b1;
                            state_next       = S_IDLE;
                        end
                    end
                end
            end
            S_DECODE:
            begin
                if (stat.out_space)
                begin
                    cmd.dec_step = 1'b1;
                    if (stat.dec_bad || stat.dec_last)
                    begin
                        cmd.emit_decode = 1'b1;
                        state_next      = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/sbcd_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// sbcd_datapath - capture and decode datapath
// Budget counter, bit counter, kept-byte shift line, digit accumulator and
// the registered result stage.
// ============================================================================
module sbcd_datapath #(
    parameter int FRAME_BYTES  = 58,
    parameter int DIGIT_OFFSET = 40,
    parameter int DIGIT_COUNT  = 5
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sbcd_pkg::BUDGET_W-1:0]    cfg_wdata,
    input  logic                             data_level,
    input  sbcd_pkg::cmd_t                   cmd,
    output sbcd_pkg::stat_t                  stat,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [sbcd_pkg::READING_W-1:0]   out_reading,
    output sbcd_pkg::status_t                out_status
);

    localparam int FRAME_BITS = FRAME_BYTES * 8;
    localparam int BW         = $clog2(FRAME_BITS);
    localparam int KEPT_W     = 2 * DIGIT_COUNT * 8;
    localparam int WIN_LO     = DIGIT_OFFSET * 8;
    localparam int WIN_HI     = (DIGIT_OFFSET + 2 * DIGIT_COUNT) * 8;
    localparam int DW         = $clog2(DIGIT_COUNT + 1);
    localparam logic [BW-1:0] LAST_BIT   = BW'(FRAME_BITS - 1);
    localparam logic [DW-1:0] LAST_DIGIT = DW'(DIGIT_COUNT - 1);

    logic [sbcd_pkg::BUDGET_W-1:0]  wait_budget_reg;
    logic [sbcd_pkg::BUDGET_W-1:0]  budget_left_reg;
    logic                           edge_armed_reg;
    logic [BW-1:0]                  bit_index_reg;
    logic [KEPT_W-1:0]              kept_reg;
    logic [sbcd_pkg::READING_W-1:0] acc_reg;
    logic [DW-1:0]                  digit_reg;
    logic                           out_valid_reg;
    logic [sbcd_pkg::READING_W-1:0] reading_reg;
    sbcd_pkg::status_t              status_reg;

    logic [31:0]                    bit_wide;
    logic                           in_window;
    logic [7:0]                     code;
    logic [4:0]                     lookup;
    logic [sbcd_pkg::READING_W-1:0] acc_next;
    logic [sbcd_pkg::READING_W-1:0] res_reading;
    sbcd_pkg::status_t              res_status;

    assign bit_wide  = 32'(bit_index_reg);
    assign in_window = (bit_wide >= 32'(WIN_LO)) && (bit_wide < 32'(WIN_HI));

    // The most recently shifted pair sits in the low bits: that is the most
    // significant digit, so the accumulator takes it first.
    assign code     = sbcd_pkg::seg_code(kept_reg[15:8], kept_reg[7:0]);
    assign lookup   = sbcd_pkg::seg_lookup(code);
    assign acc_next = sbcd_pkg::READING_W'(acc_reg * 16'd10 + {12'd0, lookup[3:0]});

    assign stat.edge_armed = edge_armed_reg;
    assign stat.budget_low = (budget_left_reg <= 16'd1);
    assign stat.last_bit   = (bit_index_reg == LAST_BIT);
    assign stat.dec_last   = (digit_reg == LAST_DIGIT);
    assign stat.dec_bad    = !lookup[4];
    assign stat.out_space  = !out_valid_reg || out_ready;

    always_comb
    begin
        if (cmd.emit_timeout)
        begin
            res_reading = '0;
            res_status  = sbcd_pkg::ST_TIMEOUT;
        end
        else if (!lookup[4])
        begin
            res_reading = '0;
            res_status  = sbcd_pkg::ST_BADCODE;
        end
        else if (acc_next == sbcd_pkg::RESERVED_VALUE)
        begin
            res_reading = '0;
            res_status  = sbcd_pkg::ST_RESERVED;
        end
        else
        begin
            res_reading = acc_next;
            res_status  = sbcd_pkg::ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_budget_reg <= 16'hffff;
            budget_left_reg <= '0;
            edge_armed_reg  <= 1'b0;
            bit_index_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                wait_budget_reg <= cfg_wdata;
            end

            if (cmd.load)
            begin
                budget_left_reg <= wait_budget_reg;
            end
            else if (cmd.spend)
            begin
                budget_left_reg <= stat.budget_low ? '0 : budget_left_reg - 16'd1;
            end

            if (cmd.load || cmd.clear_cap || cmd.disarm || cmd.sample)
            begin
                edge_armed_reg <= 1'b0;
            end
            else if (cmd.arm)
            begin
                edge_armed_reg <= 1'b1;
            end

            if (cmd.load || cmd.clear_cap)
            begin
                bit_index_reg <= '0;
            end
            else if (cmd.sample)
            begin
                bit_index_reg <= stat.last_bit ? '0 : bit_index_reg + 1'b1;
            end

            if (cmd.emit_timeout || cmd.emit_decode)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.sample && in_window)
        begin
            kept_reg <= {kept_reg[KEPT_W-2:0], data_level};
        end
        else if (cmd.dec_step)
        begin
            kept_reg <= kept_reg >> 16;
        end

        if (cmd.dec_start)
        begin
            acc_reg   <= '0;
            digit_reg <= '0;
        end
        else if (cmd.dec_step)
        begin
            acc_reg   <= acc_next;
            digit_reg <= digit_reg + 1'b1;
        end

        if (cmd.emit_timeout || cmd.emit_decode)
        begin
            reading_reg <= res_reading;
            status_reg  <= res_status;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_reading = reading_reg;
    assign out_status  = status_reg;

endmodule

// File: tb/sv/sbcd_reading_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// sbcd_reading_checker - reading predictor and result checker
// Watches the sample channel, the result channel and the budget register
// write port. It predicts every reading and status that the decoder has to
// report, and compares each result transaction with the oldest prediction.
// ============================================================================
module sbcd_reading_checker #(
    parameter int FRAME_BYTES  = 58,
    parameter int DIGIT_OFFSET = 40,
    parameter int DIGIT_COUNT  = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    sbcd_in_if          in_mon,
    sbcd_out_if         out_mon,
    output int          mismatches,
    output int          results_due,
    output int          results_open,
    output logic        capture_idle,
    output int          status_seen [4]
);
    import sbcd_pkg::*;

    localparam int FRAME_BITS = FRAME_BYTES * 8;
    localparam int KEPT_BYTES = 2 * DIGIT_COUNT;

    localparam logic [7:0] DIGIT_SEG [10] = '{
        8'haf, 8'h06, 8'h6d, 8'h4f, 8'hc6, 8'hcb, 8'heb, 8'h0e, 8'hef, 8'hcf
    };
    localparam logic [7:0] BLANK_SEG = 8'h00;

    typedef enum logic [1:0] {
        CAP_IDLE,
        CAP_WAIT_HIGH,
        CAP_WAIT_LOW,
        CAP_BITS
    } cap_phase_t;

    typedef struct packed {
        logic [READING_W-1:0] reading;
        status_t              status;
    } reading_t;

    logic [BUDGET_W-1:0] wait_budget;
    cap_phase_t          phase;
    logic                armed;
    logic [8:0]          bit_cnt;
    logic [BUDGET_W-1:0] budget_left;
    logic [7:0]          kept [KEPT_BYTES];
    reading_t            due_readings [$];
    reading_t            head;

    assign capture_idle = (phase == CAP_IDLE);

    initial
    begin
        mismatches  = 0;
        results_due = 0;
        for (int s = 0; s < 4; s++)
        begin
            status_seen[s] = 0;
        end
    end

    // Folds the kept byte pairs into a value, most significant pair first.
    function automatic reading_t decode_kept();
        reading_t   res;
        logic [7:0] code;
        logic [31:0] value;
        int         digit;
        bit         known;
        value = 32'd0;
        for (int k = DIGIT_COUNT - 1; k >= 0; k--)
        begin
            code  = {kept[2*k][6:4], 1'b0, kept[2*k][2:0], kept[2*k+1][7]};
            known = (code == BLANK_SEG);
            digit = 0;
            for (int t = 0; t < 10; t++)
            begin
                if (DIGIT_SEG[t] == code)
                begin
                    known = 1'b1;
                    digit = t;
                end
            end
            if (!known)
            begin
                res.reading = '0;
                res.status  = ST_BADCODE;
                return res;
            end
            value = (value * 10 + digit) & 32'h0000_FFFF;
        end
        if (value[15:0] == RESERVED_VALUE)
        begin
            res.reading = '0;
            res.status  = ST_RESERVED;
        end
        else
        begin
            res.reading = value[15:0];
            res.status  = ST_OK;
        end
        return res;
    endfunction

    // One waiting transaction: either uses a unit of budget or times out.
    task automatic spend_wait();
        reading_t res;
        if (budget_left <= 1)
        begin
            budget_left = '0;
            phase       = CAP_IDLE;
            armed       = 1'b0;
            res.reading = '0;
            res.status  = ST_TIMEOUT;
            due_readings.push_back(res);
            results_due++;
        end
        else
        begin
            budget_left = budget_left - 1'b1;
        end
    endtask

    task automatic track_sample(input logic start, input logic frame,
                                input logic sclk, input logic data);
        int idx;
        case (phase)
            CAP_IDLE:
            begin
                if (start)
                begin
                    budget_left = wait_budget;
                    armed       = 1'b0;
                    bit_cnt     = '0;
                    phase       = CAP_WAIT_HIGH;
                end
            end
            CAP_WAIT_HIGH:
            begin
                if (frame)
                    phase = CAP_WAIT_LOW;
                else
                    spend_wait();
            end
            CAP_WAIT_LOW:
            begin
                if (!frame)
                begin
                    phase   = CAP_BITS;
                    armed   = 1'b0;
                    bit_cnt = '0;
                end
                else
                begin
                    spend_wait();
                end
            end
            default:
            begin
                if (!armed || !sclk)
                begin
                    if (!sclk)
                        armed = 1'b1;
                    spend_wait();
                end
                else
                begin
                    armed = 1'b0;
                    idx   = int'(bit_cnt >> 3) - DIGIT_OFFSET;
                    if (idx >= 0 && idx < KEPT_BYTES)
                        kept[idx] = {kept[idx][6:0], data};
                    bit_cnt = bit_cnt + 9'd1;
                    if (int'(bit_cnt) >= FRAME_BITS)
                    begin
                        phase   = CAP_IDLE;
                        bit_cnt = '0;
                        due_readings.push_back(decode_kept());
                        results_due++;
                    end
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_budget = 16'hFFFF;
            phase       = CAP_IDLE;
            armed       = 1'b0;
            bit_cnt     = '0;
            budget_left = '0;
            for (int k = 0; k < KEPT_BYTES; k++)
            begin
                kept[k] = 8'h00;
            end
            due_readings.delete();
        end
        else
        begin
            // Results are checked before the same edge's sample is predicted;
            // a sample never produces its result in the cycle it is taken.
            if (out_mon.valid && out_mon.ready)
            begin
                if (due_readings.size() == 0)
                begin
                    $error("unexpected result: reading %0d, status %0d",
                           out_mon.reading, out_mon.status);
                    mismatches++;
                end
                else
                begin
                    head = due_readings.pop_front();
                    status_seen[head.status]++;
                    if (out_mon.reading !== head.reading)
                    begin
                        $error("reading: expected %0d, actual %0d",
                               head.reading, out_mon.reading);
                        mismatches++;
                    end
                    if (out_mon.status !== head.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               head.status, out_mon.status);
                        mismatches++;
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
                track_sample(in_mon.start_req, in_mon.frame_level,
                             in_mon.clock_level, in_mon.data_level);
            if (cfg_we)
                wait_budget = cfg_wdata;
        end
        results_open = due_readings.size();
    end

endmodule

// File: tb/sv/segment_bus_capture_decoder_core_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// segment_bus_capture_decoder_core_tb - testbench of the capture decoder
// Feeds bus samples that form whole display frames, broken frames and noise,
// under several wait budgets and idle patterns, and lets the reading checker
// compare every result transaction with its own prediction.
// ============================================================================
module segment_bus_capture_decoder_core_tb;
    import sbcd_pkg::*;

    localparam int FRAME_BYTES  = 58;
    localparam int DIGIT_OFFSET = 40;
    localparam int DIGIT_COUNT  = 5;
    localparam int FRAME_BITS   = FRAME_BYTES * 8;
    localparam int HOLD_CYCLES  = 400;

    // Segment codes of the decimal digits, as the display drives them.
    localparam logic [7:0] DIGIT_SEG [10] = '{
        8'haf, 8'h06, 8'h6d, 8'h4f, 8'hc6, 8'hcb, 8'heb, 8'h0e, 8'hef, 8'hcf
    };

    typedef logic [7:0] seg_set_t [DIGIT_COUNT];

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [BUDGET_W-1:0] cfg_wdata;

    sbcd_in_if  in_bus ();
    sbcd_out_if out_bus ();

    int   send_idle_pct;
    int   recv_idle_pct;
    bit   hold_go;
    int   samples_sent;

    int   mismatches;
    int   results_due;
    int   results_open;
    logic capture_idle;
    int   status_seen [4];

    segment_bus_capture_decoder_core #(
        .FRAME_BYTES  (FRAME_BYTES),
        .DIGIT_OFFSET (DIGIT_OFFSET),
        .DIGIT_COUNT  (DIGIT_COUNT)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_bus    (in_bus),
        .out_bus   (out_bus)
    );

    sbcd_reading_checker #(
        .FRAME_BYTES  (FRAME_BYTES),
        .DIGIT_OFFSET (DIGIT_OFFSET),
        .DIGIT_COUNT  (DIGIT_COUNT)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_mon       (in_bus),
        .out_mon      (out_bus),
        .mismatches   (mismatches),
        .results_due  (results_due),
        .results_open (results_open),
        .capture_idle (capture_idle),
        .status_seen  (status_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Hard stop. The slowest legal run is far below this.
    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic bit coin(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic logic any_level();
        return 1'($urandom_range(1));
    endfunction

    // Least significant digit goes to pair 0, as the display sends it.
    function automatic seg_set_t digits_to_seg(input int unsigned value);
        seg_set_t seg;
        for (int k = 0; k < DIGIT_COUNT; k++)
        begin
            seg[k] = DIGIT_SEG[value % 10];
            value  = value / 10;
        end
        return seg;
    endfunction

    // The receiver. Outside its long hold-off it drops ready at random, at the
    // rate of the current idle pattern. The one long hold-off is counted here
    // so that the sender keeps offering transactions while the result channel
    // is blocked and the block has to stall its input.
    initial
    begin
        int hold_left;
        bit hold_seen;
        hold_left     = 0;
        hold_seen     = 1'b0;
        out_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_seen)
            begin
                hold_seen = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_bus.ready = 1'b0;
            end
            else
            begin
                out_bus.ready = !coin(recv_idle_pct);
            end
        end
    end

    // Offers one sample transaction and returns at the falling edge after it
    // was taken. Valid stays high on return so that back-to-back transactions
    // need no second write of valid in one time step; callers that pause lower
    // it themselves.
    task automatic push_sample(input logic start, input logic frame,
                               input logic sclk, input logic data);
        while (coin(send_idle_pct))
        begin
            in_bus.valid = 1'b0;
            @(negedge clk);
        end
        in_bus.valid       = 1'b1;
        in_bus.start_req   = start;
        in_bus.frame_level = frame;
        in_bus.clock_level = sclk;
        in_bus.data_level  = data;
        @(posedge clk);
        while (!in_bus.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        samples_sent++;
    endtask

    // Sends one display frame: start, frame high, frame low, then one clock
    // rising edge per bit up to cut_at. The digit pairs carry the given
    // segment codes; the bits the decoder masks off are random, and so is
    // every byte outside the digit window. With noise_pct above zero, extra
    // waiting transactions and stray start requests are mixed in.
    task automatic send_frame(input seg_set_t seg, input int noise_pct,
                              input int cut_at);
        logic [7:0] frame_bytes [FRAME_BYTES];
        int         pos;
        for (int b = 0; b < FRAME_BYTES; b++)
        begin
            frame_bytes[b] = 8'($urandom());
        end
        for (int k = 0; k < DIGIT_COUNT; k++)
        begin
            pos = DIGIT_OFFSET + 2 * k;
            frame_bytes[pos]     = {any_level(), seg[k][7:5], any_level(), seg[k][3:1]};
            frame_bytes[pos + 1] = {seg[k][0], 7'($urandom())};
        end
        push_sample(1'b1, any_level(), any_level(), any_level());
        while (coin(noise_pct))
        begin
            push_sample(coin(50), 1'b0, any_level(), any_level());
        end
        push_sample(coin(noise_pct), 1'b1, any_level(), any_level());
        while (coin(noise_pct))
        begin
            push_sample(coin(50), 1'b1, any_level(), any_level());
        end
        push_sample(coin(noise_pct), 1'b0, any_level(), any_level());
        for (int b = 0; b < cut_at; b++)
        begin
            // Clock still high from the last bit: no edge yet.
            while (coin(noise_pct))
            begin
                push_sample(coin(50), any_level(), 1'b1, any_level());
            end
            push_sample(coin(noise_pct), any_level(), 1'b0, any_level());
            while (coin(noise_pct))
            begin
                push_sample(coin(50), any_level(), 1'b0, any_level());
            end
            push_sample(coin(noise_pct), any_level(), 1'b1,
                        frame_bytes[b / 8][7 - (b % 8)]);
        end
    endtask

    // One random capture attempt. Most are well-formed frames with random
    // digits; the rest are bare starts with random waiting, frames cut off
    // part way, and plain noise. Cut-off attempts leave the block busy, so the
    // next frame lands in the middle of a capture.
    task automatic random_capture();
        seg_set_t seg;
        int       pick;
        pick = $urandom_range(99);
        seg  = digits_to_seg($urandom_range(99999));
        for (int k = 0; k < DIGIT_COUNT; k++)
        begin
            if (coin(10))
                seg[k] = 8'h00;
        end
        if (coin(15))
            seg[$urandom_range(DIGIT_COUNT - 1)] = 8'($urandom());
        if (coin(5))
            seg = digits_to_seg(int'(RESERVED_VALUE));
        if (pick < 55)
        begin
            send_frame(seg, $urandom_range(4), FRAME_BITS);
        end
        else if (pick < 70)
        begin
            push_sample(1'b1, any_level(), any_level(), any_level());
            repeat ($urandom_range(1, 12))
            begin
                push_sample(any_level(), any_level(), any_level(), any_level());
            end
        end
        else if (pick < 85)
        begin
            send_frame(seg, $urandom_range(4), $urandom_range(FRAME_BITS - 1));
        end
        else
        begin
            repeat ($urandom_range(1, 20))
            begin
                push_sample(any_level(), any_level(), any_level(), any_level());
            end
        end
    endtask

    task automatic run_random(input int want);
        int goal;
        goal = results_due + want;
        while (results_due < goal)
        begin
            random_capture();
        end
    endtask

    // Brings the block back to idle before the budget register is touched.
    // A capture still in progress is driven to its end with a fixed pattern
    // that also gets through both frame waits: frame high with clock low,
    // then frame low with clock high. Then all results must have arrived, and
    // the decoder is left to finish its pair folding.
    task automatic settle();
        bit toggle;
        toggle = 1'b0;
        while (!capture_idle)
        begin
            if (toggle)
                push_sample(1'b0, 1'b0, 1'b1, any_level());
            else
                push_sample(1'b0, 1'b1, 1'b0, any_level());
            toggle = !toggle;
        end
        in_bus.valid = 1'b0;
        while (results_open != 0)
        begin
            @(negedge clk);
        end
        repeat (DIGIT_COUNT + 4) @(negedge clk);
    endtask

    task automatic put_budget(input logic [BUDGET_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    initial
    begin
        seg_set_t seg;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        in_bus.valid       = 1'b0;
        in_bus.start_req   = 1'b0;
        in_bus.frame_level = 1'b0;
        in_bus.clock_level = 1'b0;
        in_bus.data_level  = 1'b0;
        send_idle_pct      = 10;
        recv_idle_pct      = 61;
        hold_go            = 1'b0;
        samples_sent       = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed frames under the reset budget. All blank digits read 0;
        // 99999 and 65536 wrap; 65535 is the top of the reading field; 2080
        // is the reserved value, reached directly and through the wrap.
        seg = '{default: 8'h00};
        send_frame(seg, 0, FRAME_BITS);
        send_frame(digits_to_seg(99999), 0, FRAME_BITS);
        send_frame(digits_to_seg(65535), 0, FRAME_BITS);
        send_frame(digits_to_seg(65536), 0, FRAME_BITS);
        send_frame(digits_to_seg(2080), 0, FRAME_BITS);
        send_frame(digits_to_seg(67616), 0, FRAME_BITS);
        send_frame(digits_to_seg(48760), 0, FRAME_BITS);
        // A code that is not in the segment table.
        seg    = digits_to_seg(12345);
        seg[2] = 8'h02;
        send_frame(seg, 0, FRAME_BITS);
        // Extra waiting and start requests while the capture is busy.
        send_frame(digits_to_seg(12345), 20, FRAME_BITS);
        settle();

        // Budget of one: timeout while waiting for frame high, then while
        // waiting for frame low.
        put_budget(16'd1);
        push_sample(1'b1, 1'b0, 1'b0, 1'b0);
        push_sample(1'b0, 1'b0, 1'b1, 1'b1);
        push_sample(1'b1, 1'b1, 1'b1, 1'b1);
        push_sample(1'b0, 1'b1, 1'b0, 1'b0);
        push_sample(1'b0, 1'b1, 1'b0, 1'b1);
        // Long receiver hold-off while short timeouts keep coming: the output
        // register fills and the sample channel has to stall.
        hold_go = 1'b1;
        repeat (12)
        begin
            push_sample(1'b1, 1'b0, any_level(), any_level());
            push_sample(1'b0, 1'b0, any_level(), any_level());
        end
        settle();

        // Timeout during the bit capture, on clock-low transactions.
        put_budget(16'd3);
        push_sample(1'b1, 1'b0, 1'b0, 1'b0);
        push_sample(1'b0, 1'b1, 1'b0, 1'b0);
        push_sample(1'b0, 1'b0, 1'b1, 1'b1);
        repeat (3)
        begin
            push_sample(1'b0, any_level(), 1'b0, any_level());
        end
        settle();

        // Random phases. A budget close to one frame's worth of waiting makes
        // the outcome depend on how much noise a frame carries.
        put_budget(16'($urandom_range(470, 520)));
        run_random(8);
        settle();

        send_idle_pct = 61;
        recv_idle_pct = 10;
        put_budget(16'hFFFF);
        run_random(8);
        settle();
        put_budget(16'($urandom_range(2, 40)));
        run_random(8);
        settle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        put_budget(16'($urandom_range(900, 3000)));
        run_random(8);
        settle();
        put_budget(16'd1);
        run_random(8);
        settle();

        $display("Run covered %0d sample transactions and %0d results: ok %0d, timeout %0d,",
                 samples_sent, results_due, status_seen[ST_OK], status_seen[ST_TIMEOUT]);
        $display("bad code %0d, reserved %0d, with budgets from 1 to 65535 and a long stall.",
                 status_seen[ST_BADCODE], status_seen[ST_RESERVED]);
        if (mismatches == 0 && results_open == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
